>>> hdl/lbca_pkg.sv
// lbca_pkg: shared types, constants and helpers of the linked block chain allocator
// used by every module of the block but lbca_ram; depends on nothing
`default_nettype none

package lbca_pkg;

  // table geometry and field widths
  localparam int NUM_BLOCKS = 1024;
  localparam int ID_W       = $clog2(NUM_BLOCKS);
  localparam int CNT_W      = ID_W + 1;
  localparam int OP_W       = 2;

  // opcodes on the input channel
  localparam logic [OP_W-1:0] OP_ACQUIRE = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOKUP  = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_ZERO    = 2'd2,
    ST_CORRUPT = 2'd3
  } status_t;

  // command kinds after front-end decode
  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_ZERO,
    CMD_ACQUIRE,
    CMD_RELEASE,
    CMD_LOOKUP
  } cmd_kind_t;

  // one queued command
  typedef struct packed {
    cmd_kind_t        kind;
    logic [ID_W-1:0]  blk_idx;
    logic [CNT_W-1:0] count;
  } cmd_t;

  // queue to back-end handoff
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_ACQ,
    BK_REL,
    BK_LKP
  } bk_state_t;

  // reset contents of one link entry: 0 self, i to i+1, last self
  function automatic logic [ID_W-1:0] init_link(input logic [ID_W-1:0] idx);
    logic [ID_W-1:0] res;
    if (idx == '0) begin
      res = '0;
    end else if (idx == ID_W'(NUM_BLOCKS - 1)) begin
      res = idx;
    end else begin
      res = idx + ID_W'(1);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> hdl/lbca_ram.sv
// lbca_ram: generic single-write, single-read RAM with registered read data
// standalone; no package needed
`default_nettype none

module lbca_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/lbca_front.sv
// lbca_front: accepts input words, decodes them into commands, two-entry queue
// depends on lbca_pkg
`default_nettype none

module lbca_front
  import lbca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [OP_W-1:0]  in_op,
  input  wire logic [ID_W-1:0]  in_blk_idx,
  input  wire logic [CNT_W-1:0] in_count,
  input  wire logic             init_busy,
  output      cmd_q_t           q_out,
  input  wire logic             q_pop
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  cmd_t       dec;

  // classify the incoming word
  always_comb begin
    dec.blk_idx = in_blk_idx;
    dec.count   = in_count;
    unique case (in_op)
      OP_ACQUIRE: dec.kind = (in_count == '0) ? CMD_ZERO : CMD_ACQUIRE;
      OP_RELEASE: dec.kind = CMD_RELEASE;
      OP_LOOKUP:  dec.kind = CMD_LOOKUP;
      OP_UNUSED:  dec.kind = CMD_NOP;
      default:    dec.kind = CMD_NOP;
    endcase
  end

  // handshake and queue pointers
  assign in_ready = (fill_r != 2'd2) && !init_busy;
  assign push     = in_valid && in_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec;
    end
  end

  assign q_out.valid = (fill_r != 2'd0);
  assign q_out.cmd   = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

>>> hdl/lbca_back.sv
// lbca_back: executes queued commands by walking the link memory, holds the result word
// depends on lbca_pkg and lbca_ram
`default_nettype none

module lbca_back
  import lbca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_q_t           q_in,
  output      logic             q_pop,
  output      logic             init_busy,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [ID_W-1:0]  out_result_id,
  output      logic             out_is_tail,
  output      logic [1:0]       out_status,
  output      logic [CNT_W-1:0] out_free_count
);

  bk_state_t        state_r, state_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [ID_W-1:0]  head_r, head_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] size_r, size_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [ID_W-1:0]  free_head_r, free_head_nxt;
  logic [CNT_W-1:0] free_total_r, free_total_nxt;
  logic [ID_W-1:0]  init_idx_r, init_idx_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]  out_id_r, out_id_nxt;
  logic             out_tail_r, out_tail_nxt;
  status_t          out_st_r, out_st_nxt;
  logic [CNT_W-1:0] out_free_r, out_free_nxt;

  logic             slot_free;
  logic             load;
  logic             ram_we;
  logic [ID_W-1:0]  ram_waddr, ram_wdata, ram_raddr, ram_rdata;
  logic [CNT_W:0]   rel_total;

  // link memory
  lbca_ram #(
    .WIDTH(ID_W),
    .DEPTH(NUM_BLOCKS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign slot_free = !out_valid_r || out_ready;
  assign init_busy = (state_r == BK_INIT);
  assign rel_total = {1'b0, size_r} + {1'b0, free_total_r};

  // sequencer: next state, memory access and result load
  always_comb begin
    state_nxt      = state_r;
    tail_nxt       = tail_r;
    head_nxt       = head_r;
    remain_nxt     = remain_r;
    size_nxt       = size_r;
    cnt_nxt        = cnt_r;
    free_head_nxt  = free_head_r;
    free_total_nxt = free_total_r;
    init_idx_nxt   = init_idx_r;
    q_pop          = 1'b0;
    load           = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail_r;
    ram_wdata      = tail_r;
    ram_raddr      = tail_r;
    out_id_nxt     = '0;
    out_tail_nxt   = 1'b0;
    out_st_nxt     = ST_OK;
    out_free_nxt   = free_total_r;

    unique case (state_r)
      // clearing pass: one entry per cycle
      BK_INIT: begin
        ram_we       = 1'b1;
        ram_waddr    = init_idx_r;
        ram_wdata    = init_link(init_idx_r);
        init_idx_nxt = init_idx_r + ID_W'(1);
        if (init_idx_r == ID_W'(NUM_BLOCKS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end

      // dispatch the next command
      BK_IDLE: begin
        if (q_in.valid) begin
          unique case (q_in.cmd.kind)
            CMD_NOP: begin
              if (slot_free) begin
                q_pop = 1'b1;
                load  = 1'b1;
              end
            end
            CMD_ZERO: begin
              if (slot_free) begin
                q_pop      = 1'b1;
                load       = 1'b1;
                out_st_nxt = ST_ZERO;
              end
            end
            CMD_ACQUIRE: begin
              if (q_in.cmd.count >= free_total_r) begin
                if (slot_free) begin
                  q_pop      = 1'b1;
                  load       = 1'b1;
                  out_st_nxt = ST_NOSPACE;
                end
              end else begin
                q_pop      = 1'b1;
                tail_nxt   = free_head_r;
                remain_nxt = q_in.cmd.count;
                cnt_nxt    = q_in.cmd.count;
                ram_raddr  = free_head_r;
                state_nxt  = BK_ACQ;
              end
            end
            CMD_RELEASE: begin
              q_pop     = 1'b1;
              tail_nxt  = q_in.cmd.blk_idx;
              head_nxt  = q_in.cmd.blk_idx;
              size_nxt  = CNT_W'(1);
              ram_raddr = q_in.cmd.blk_idx;
              state_nxt = BK_REL;
            end
            CMD_LOOKUP: begin
              q_pop     = 1'b1;
              tail_nxt  = q_in.cmd.blk_idx;
              ram_raddr = q_in.cmd.blk_idx;
              state_nxt = BK_LKP;
            end
            default: begin
            end
          endcase
        end
      end

      // acquire walk down the free list
      BK_ACQ: begin
        if (ram_rdata == tail_r) begin
          // free list ends early
          if (slot_free) begin
            load       = 1'b1;
            out_st_nxt = ST_CORRUPT;
            state_nxt  = BK_IDLE;
          end
        end else if (remain_r == CNT_W'(1)) begin
          if (slot_free) begin
            ram_we         = 1'b1;
            free_head_nxt  = ram_rdata;
            free_total_nxt = free_total_r - cnt_r;
            load           = 1'b1;
            out_id_nxt     = free_head_r;
            out_free_nxt   = free_total_r - cnt_r;
            state_nxt      = BK_IDLE;
          end
        end else begin
          tail_nxt   = ram_rdata;
          remain_nxt = remain_r - CNT_W'(1);
          ram_raddr  = ram_rdata;
        end
      end

      // release walk to the chain tail
      BK_REL: begin
        if (ram_rdata == tail_r) begin
          if (slot_free) begin
            load      = 1'b1;
            state_nxt = BK_IDLE;
            if (rel_total > (CNT_W + 1)'(NUM_BLOCKS)) begin
              out_st_nxt = ST_CORRUPT;
            end else begin
              ram_we         = 1'b1;
              ram_wdata      = free_head_r;
              free_head_nxt  = head_r;
              free_total_nxt = rel_total[CNT_W-1:0];
              out_free_nxt   = rel_total[CNT_W-1:0];
            end
          end
        end else if (size_r >= CNT_W'(NUM_BLOCKS)) begin
          // no tail within the table size
          if (slot_free) begin
            load       = 1'b1;
            out_st_nxt = ST_CORRUPT;
            state_nxt  = BK_IDLE;
          end
        end else begin
          tail_nxt  = ram_rdata;
          size_nxt  = size_r + CNT_W'(1);
          ram_raddr = ram_rdata;
        end
      end

      // lookup answer
      BK_LKP: begin
        if (slot_free) begin
          load         = 1'b1;
          out_id_nxt   = ram_rdata;
          out_tail_nxt = (ram_rdata == tail_r);
          state_nxt    = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase

    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_INIT;
      init_idx_r   <= '0;
      free_head_r  <= ID_W'(1);
      free_total_r <= CNT_W'(NUM_BLOCKS - 1);
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_idx_r   <= init_idx_nxt;
      free_head_r  <= free_head_nxt;
      free_total_r <= free_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // walk and result payload registers
  always_ff @(posedge clk) begin
    tail_r   <= tail_nxt;
    head_r   <= head_nxt;
    remain_r <= remain_nxt;
    size_r   <= size_nxt;
    cnt_r    <= cnt_nxt;
    if (load) begin
      out_id_r   <= out_id_nxt;
      out_tail_r <= out_tail_nxt;
      out_st_r   <= out_st_nxt;
      out_free_r <= out_free_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_id  = out_id_r;
  assign out_is_tail    = out_tail_r;
  assign out_status     = out_st_r;
  assign out_free_count = out_free_r;

endmodule

`default_nettype wire

>>> hdl/linked_block_chain_allocator.sv
// Linked block chain allocator: decode front end with a two-word queue, walking back end.
// Unused ops, zero count and no space answer from the dispatch state; lookup reads one link,
// acquire and release walk their chain; the link memory read loop takes one step per cycle.
// The back end runs one command at a time while the queue takes further words; results are held in an output register.
// Reset: a clearing pass rebuilds the link table; no input word is taken then.
// Depends on lbca_pkg, lbca_front, lbca_back, lbca_ram.
`default_nettype none

module linked_block_chain_allocator
  import lbca_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [OP_W-1:0]  in_op,
  input  wire logic [ID_W-1:0]  in_blk_idx,
  input  wire logic [CNT_W-1:0] in_count,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      logic [ID_W-1:0]  out_result_id,
  output      logic             out_is_tail,
  output      logic [1:0]       out_status,
  output      logic [CNT_W-1:0] out_free_count
);

  cmd_q_t q_cmd;
  logic   q_pop;
  logic   init_busy;

  // accept and classify
  lbca_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_blk_idx (in_blk_idx),
    .in_count   (in_count),
    .init_busy  (init_busy),
    .q_out      (q_cmd),
    .q_pop      (q_pop)
  );

  // execute against the link memory
  lbca_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_in          (q_cmd),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_result_id (out_result_id),
    .out_is_tail   (out_is_tail),
    .out_status    (out_status),
    .out_free_count(out_free_count)
  );

endmodule

`default_nettype wire

>>> tb/tb.sv
// self-checking testbench of linked_block_chain_allocator: a shadow link table predicts every
// result word, directed chains then random acquire/release/lookup traffic with random stalls
// depends on lbca_pkg and linked_block_chain_allocator
`timescale 1ns / 1ps

import lbca_pkg::*;

// one expected result word
typedef struct packed {
  logic [ID_W-1:0]  result_id;
  logic             is_tail;
  status_t          status;
  logic [CNT_W-1:0] free_count;
} alloc_result_t;

// shadow allocator state and the queue of result words still to come
class chain_scoreboard;
  logic [ID_W-1:0] link_mem [NUM_BLOCKS];
  logic [ID_W-1:0] free_head;
  int              free_total;
  alloc_result_t   pending_results[$];
  int unsigned     held_heads[$];
  int unsigned     mismatches;
  int unsigned     results_seen;
  int unsigned     status_hits[4];

  function new();
    // block 0 is a lone tail, 1 .. last form the free chain
    link_mem[0] = '0;
    for (int i = 1; i < NUM_BLOCKS - 1; i++) link_mem[i] = ID_W'(i + 1);
    link_mem[NUM_BLOCKS - 1] = ID_W'(NUM_BLOCKS - 1);
    free_head  = ID_W'(1);
    free_total = NUM_BLOCKS - 1;
    mismatches = 0;
    results_seen = 0;
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  // unlink cnt blocks from the free head; ids are always inside the table here
  function status_t take_chain(int unsigned cnt, output logic [ID_W-1:0] head_out);
    logic [ID_W-1:0] tail;
    logic [ID_W-1:0] nxt;
    head_out = '0;
    if (cnt == 0) return ST_ZERO;
    if (int'(cnt) >= free_total) return ST_NOSPACE;
    tail = free_head;
    nxt  = '0;
    // read cnt links: the last one is the successor that becomes the new free head
    for (int unsigned i = 1; i <= cnt; i++) begin
      nxt = link_mem[tail];
      if (nxt == tail) return ST_CORRUPT;
      if (i < cnt) tail = nxt;
    end
    head_out   = free_head;
    free_head  = nxt;
    free_total = free_total - int'(cnt);
    link_mem[tail] = tail;
    return ST_OK;
  endfunction

  // walk a chain to its tail and splice it in front of the free list
  function status_t give_back_chain(logic [ID_W-1:0] head);
    logic [ID_W-1:0] tail;
    int              size;
    tail = head;
    size = 1;
    while (link_mem[tail] != tail) begin
      if (size >= NUM_BLOCKS) return ST_CORRUPT;
      tail = link_mem[tail];
      size++;
    end
    if (size > NUM_BLOCKS - free_total) return ST_CORRUPT;
    link_mem[tail] = free_head;
    free_head  = head;
    free_total = free_total + size;
    return ST_OK;
  endfunction

  // accepted input word: update the shadow state and queue the expected result
  function void note_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
    alloc_result_t   r;
    logic [ID_W-1:0] head;
    int              hit[$];
    r = '0;
    r.status = ST_OK;
    case (op)
      OP_ACQUIRE: begin
        r.status = take_chain(cnt, head);
        if (r.status == ST_OK) begin
          r.result_id = head;
          held_heads.push_back(head);
        end
      end
      OP_RELEASE: begin
        r.status = give_back_chain(id);
        if (r.status == ST_OK) begin
          hit = held_heads.find_first_index(x) with (x == id);
          if (hit.size() != 0) held_heads.delete(hit[0]);
        end
      end
      OP_LOOKUP: begin
        r.result_id = link_mem[id];
        r.is_tail   = (link_mem[id] == id);
      end
      default: ;
    endcase
    r.free_count = CNT_W'(free_total);
    pending_results.push_back(r);
  endfunction

  task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatches++;
    $display("mismatch on result word %0d: %s got %0d want %0d", results_seen, what, got,
             want);
  endtask

  // accepted result word: compare with the oldest expectation
  task check_word(logic [ID_W-1:0] rid, logic tail, logic [1:0] st, logic [CNT_W-1:0] fc);
    alloc_result_t want;
    results_seen++;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word, status", 16'(st), 16'(0));
      return;
    end
    want = pending_results.pop_front();
    status_hits[want.status]++;
    if (rid !== want.result_id) report_mismatch("result_id", 16'(rid), 16'(want.result_id));
    if (tail !== want.is_tail) report_mismatch("is_tail", 16'(tail), 16'(want.is_tail));
    if (st !== want.status) report_mismatch("status", 16'(st), 16'(want.status));
    if (fc !== want.free_count) report_mismatch("free_count", 16'(fc), 16'(want.free_count));
  endtask
endclass

module tb;

  localparam int RANDOM_WORDS = 1625;
  localparam int CALM_FROM    = 1425;
  localparam int PAUSE_AT     = 800;
  localparam int STALL_LIMIT  = 8000;
  localparam int DRAIN_CYCLES = 1100;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [OP_W-1:0]  in_op;
  logic [ID_W-1:0]  in_blk_idx;
  logic [CNT_W-1:0] in_count;
  logic             out_valid;
  logic             out_ready;
  logic [ID_W-1:0]  out_result_id;
  logic             out_is_tail;
  logic [1:0]       out_status;
  logic [CNT_W-1:0] out_free_count;

  chain_scoreboard sb;
  bit              idling_on;
  int unsigned     op_hits[4];
  int unsigned     stall_cycles;

  // scratch for the stimulus
  int unsigned pick;
  int unsigned cnt_pick;
  int unsigned id_pick;
  int unsigned slot;
  int unsigned h_a;
  int unsigned h_b;
  int unsigned h_big;
  int unsigned h_c;
  int unsigned mid_id;

  linked_block_chain_allocator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_blk_idx     (in_blk_idx),
    .in_count       (in_count),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_result_id  (out_result_id),
    .out_is_tail    (out_is_tail),
    .out_status     (out_status),
    .out_free_count (out_free_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // present one word and hold it until it is taken
  task automatic send_word(logic [OP_W-1:0] op, logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
    in_valid   <= 1'b1;
    in_op      <= op;
    in_blk_idx <= id;
    in_count   <= cnt;
    do @(posedge clk); while (!in_ready);
    sb.note_word(op, id, cnt);
    op_hits[op]++;
  endtask

  // random sender gap between words
  task automatic sender_gap();
    if (idling_on && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk);
    end
  endtask

  // result side: random stall bursts while idling is on
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (idling_on && $urandom_range(3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_word(out_result_id, out_is_tail, out_status, out_free_count);
  end

  // watchdog on cycles without any handshake
  initial begin
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // stimulus
  initial begin
    sb = new();
    foreach (op_hits[i]) op_hits[i] = 0;
    idling_on  = 1'b1;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_op      = OP_ACQUIRE;
    in_blk_idx = '0;
    in_count   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: table edges and the reset contents
    send_word(OP_LOOKUP, ID_W'(0), CNT_W'(0));
    send_word(OP_LOOKUP, ID_W'(NUM_BLOCKS - 1), CNT_W'(2047));
    send_word(OP_LOOKUP, ID_W'(1), CNT_W'(0));
    // zero count and the no space limits
    send_word(OP_ACQUIRE, ID_W'(1023), CNT_W'(0));
    send_word(OP_ACQUIRE, ID_W'(1023), CNT_W'(1024));
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(sb.free_total));
    send_word(OP_UNUSED, ID_W'(1023), CNT_W'(1024));
    // plain acquire, lookup and release
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(1));
    h_a = sb.held_heads[$];
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(5));
    h_b = sb.held_heads[$];
    send_word(OP_LOOKUP, ID_W'(h_b), CNT_W'(0));
    send_word(OP_RELEASE, ID_W'(h_b), CNT_W'(0));
    send_word(OP_RELEASE, ID_W'(h_a), CNT_W'(0));
    // block 0 joins the free list, then a second release overflows the count
    send_word(OP_RELEASE, ID_W'(0), CNT_W'(0));
    send_word(OP_RELEASE, ID_W'(0), CNT_W'(0));
    // leave four free blocks, loop the free list and cut it short
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(sb.free_total - 4));
    h_big = sb.held_heads[$];
    send_word(OP_RELEASE, sb.link_mem[sb.link_mem[sb.free_head]], CNT_W'(0));
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(1));
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(4));
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(2));
    send_word(OP_RELEASE, ID_W'(h_big), CNT_W'(0));
    // double release of the middle of a chain
    send_word(OP_ACQUIRE, ID_W'(0), CNT_W'(3));
    h_c    = sb.held_heads[$];
    mid_id = sb.link_mem[h_c];
    send_word(OP_RELEASE, ID_W'(mid_id), CNT_W'(0));
    send_word(OP_RELEASE, ID_W'(mid_id), CNT_W'(0));
    send_word(OP_LOOKUP, ID_W'(h_c), CNT_W'(0));
    send_word(OP_RELEASE, ID_W'(h_c), CNT_W'(0));
    // the chains above overlap the free list now, keep them out of the random part
    sb.held_heads.delete();

    // random: mostly acquire/release pairs on owned chains, some lookups and noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == CALM_FROM) idling_on = 1'b0;
      if (n == PAUSE_AT) begin
        in_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
      end else begin
        sender_gap();
      end
      pick = $urandom_range(99);
      if (pick < 36 && sb.held_heads.size() > 24) pick = 50;
      if (pick >= 36 && pick < 64 && sb.held_heads.size() == 0) pick = 0;
      if (pick < 36) begin
        cnt_pick = $urandom_range(99);
        if (cnt_pick < 85) cnt_pick = $urandom_range(8, 1);
        else if (cnt_pick < 97) cnt_pick = $urandom_range(64, 1);
        else cnt_pick = $urandom_range(1024, 65);
        send_word(OP_ACQUIRE, ID_W'($urandom), CNT_W'(cnt_pick));
      end else if (pick < 64) begin
        slot    = $urandom_range(sb.held_heads.size() - 1);
        id_pick = sb.held_heads[slot];
        sb.held_heads.delete(slot);
        send_word(OP_RELEASE, ID_W'(id_pick), CNT_W'($urandom_range(1024)));
      end else if (pick < 80) begin
        if (sb.held_heads.size() != 0 && $urandom_range(1) == 0)
          id_pick = sb.held_heads[$urandom_range(sb.held_heads.size() - 1)];
        else
          id_pick = $urandom_range(NUM_BLOCKS - 1);
        send_word(OP_LOOKUP, ID_W'(id_pick), CNT_W'($urandom_range(1024)));
      end else if (pick < 86) begin
        send_word(OP_UNUSED, ID_W'($urandom), CNT_W'($urandom_range(1024)));
      end else if (pick < 93) begin
        send_word(OP_ACQUIRE, ID_W'($urandom), CNT_W'(0));
      end else begin
        send_word(OP_RELEASE, ID_W'($urandom), CNT_W'($urandom_range(1024)));
      end
    end
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_results.size() != 0)
      sb.report_mismatch("expected words left over", 16'(sb.pending_results.size()), 16'(0));

    $display("sent %0d acquire, %0d release, %0d lookup and %0d unused-op words",
             op_hits[OP_ACQUIRE], op_hits[OP_RELEASE], op_hits[OP_LOOKUP], op_hits[OP_UNUSED]);
    $display("results by status: ok %0d, no space %0d, zero count %0d, corrupt %0d",
             sb.status_hits[ST_OK], sb.status_hits[ST_NOSPACE], sb.status_hits[ST_ZERO],
             sb.status_hits[ST_CORRUPT]);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
